@@ rtl/core/pil_pkg.sv @@
// Shared types and constants of the executable image loader/relocator.
// Used by the front parser, the result queue, the back sequencer and the top level.
package pil_pkg;

  localparam int ADDR_W       = 24;
  localparam int CFG_W        = 24;
  localparam int HEADER_BYTES = 28;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;

  localparam logic [15:0]       MAGIC_WORD     = 16'h601A;
  localparam logic [CFG_W-1:0]  LOAD_BASE_RST  = 24'd2048;
  localparam logic [CFG_W-1:0]  MAX_FOOT_RST   = 24'd4192256;

  // register indexes
  localparam logic REG_LOAD_BASE = 1'b0;
  localparam logic REG_MAX_FOOT  = 1'b1;

  // command kinds
  localparam logic [2:0] K_WRITE = 3'd0;
  localparam logic [2:0] K_CLEAR = 3'd1;
  localparam logic [2:0] K_RELOC = 3'd2;
  localparam logic [2:0] K_DONE  = 3'd3;
  localparam logic [2:0] K_ERROR = 3'd4;

  // error codes
  localparam logic [2:0] E_SHORT_HDR  = 3'd0;
  localparam logic [2:0] E_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] E_TOO_LARGE  = 3'd2;
  localparam logic [2:0] E_SHORT_BODY = 3'd3;
  localparam logic [2:0] E_SHORT_SYM  = 3'd4;
  localparam logic [2:0] E_SHORT_FIX  = 3'd5;
  localparam logic [2:0] E_FIX_RANGE  = 3'd6;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
    logic [2:0]        err;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      slot;
  } bund_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                  logic [31:0] value, logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.value = value;
    r.err   = err;
    return r;
  endfunction

endpackage

@@ rtl/core/pil_front.sv @@
// Front parser: accepts file bytes, walks header/content/symbols/fixups and
// builds the bundle of results for each byte. Depends on pil_pkg.
module pil_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wen,
  input  logic                     cfg_index,
  input  logic [pil_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     acc,
  input  logic [7:0]               byte_in,
  input  logic                     eof,
  output logic                     push,
  output pil_pkg::bund_t           bund
);
  import pil_pkg::*;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_CONTENT  = 3'd1;
  localparam logic [2:0] PH_SYMBOLS  = 3'd2;
  localparam logic [2:0] PH_FIXSTART = 3'd3;
  localparam logic [2:0] PH_FIXLIST  = 3'd4;
  localparam logic [2:0] PH_STOPPED  = 3'd5;

  logic [CFG_W-1:0] base_r, maxf_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [15:0] magic_r, magic_nxt, abs_r, abs_nxt;
  logic [31:0] text_r, text_nxt, data_r, data_nxt, bss_r, bss_nxt, sym_r, sym_nxt;
  logic [31:0] fix_r, fix_nxt, total_r, total_nxt;
  logic [32:0] content_r;
  logic [33:0] foot_r;
  logic [32:0] sat_sum;
  logic        do_hdr, do_after, do_sym, do_fix, do_apply;
  logic [1:0]  n_v;
  res_t [2:0]  slot_v;

  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; magic_nxt = magic_r; abs_nxt = abs_r;
    text_nxt = text_r; data_nxt = data_r; bss_nxt = bss_r; sym_nxt = sym_r;
    fix_nxt = fix_r; total_nxt = total_r;
    do_hdr = 1'b0; do_after = 1'b0; do_sym = 1'b0; do_fix = 1'b0; do_apply = 1'b0;
    n_v = 2'd0; slot_v = '0;
    sat_sum = {1'b0, fix_r} + 33'd254;
    if (acc) begin
      case (phase_r)
        PH_HEADER: begin
          if (cnt_r < 32'd2)       magic_nxt = {magic_r[7:0], byte_in};
          else if (cnt_r < 32'd6)  text_nxt  = {text_r[23:0], byte_in};
          else if (cnt_r < 32'd10) data_nxt  = {data_r[23:0], byte_in};
          else if (cnt_r < 32'd14) bss_nxt   = {bss_r[23:0], byte_in};
          else if (cnt_r < 32'd18) sym_nxt   = {sym_r[23:0], byte_in};
          else if (cnt_r >= 32'd26 && cnt_r < 32'd28) abs_nxt = {abs_r[7:0], byte_in};
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt >= 32'(HEADER_BYTES)) begin
            do_hdr = 1'b1;
          end else if (eof) begin
            slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_HDR); n_v = n_v + 2'd1;
            phase_nxt = PH_STOPPED;
          end
        end
        PH_CONTENT: begin
          slot_v[n_v] = mk_res(K_WRITE, base_r + cnt_r[ADDR_W-1:0], {24'd0, byte_in}, '0);
          n_v = n_v + 2'd1;
          cnt_nxt = cnt_r + 32'd1;
          if ({1'b0, cnt_nxt} >= content_r) begin
            do_after = 1'b1;
          end else if (eof) begin
            slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_BODY); n_v = n_v + 2'd1;
            phase_nxt = PH_STOPPED;
          end
        end
        PH_SYMBOLS: begin
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt >= sym_r) begin
            do_fix = 1'b1;
          end else if (eof) begin
            slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_SYM); n_v = n_v + 2'd1;
            phase_nxt = PH_STOPPED;
          end
        end
        PH_FIXSTART: begin
          fix_nxt = {fix_r[23:0], byte_in};
          cnt_nxt = cnt_r + 32'd1;
          if (cnt_nxt >= 32'd4) begin
            if (fix_nxt == 32'd0) begin
              slot_v[n_v] = mk_res(K_DONE, '0, total_r, '0); n_v = n_v + 2'd1;
              phase_nxt = PH_STOPPED;
            end else begin
              do_apply = 1'b1;
            end
          end else if (eof) begin
            slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_FIX); n_v = n_v + 2'd1;
            phase_nxt = PH_STOPPED;
          end
        end
        PH_FIXLIST: begin
          if (byte_in == 8'd0) begin
            slot_v[n_v] = mk_res(K_DONE, '0, total_r, '0); n_v = n_v + 2'd1;
            phase_nxt = PH_STOPPED;
          end else begin
            if (byte_in != 8'd1) sat_sum = {1'b0, fix_r} + {25'd0, byte_in};
            fix_nxt = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
            if (byte_in != 8'd1) begin
              do_apply = 1'b1;
            end else if (eof) begin
              slot_v[n_v] = mk_res(K_DONE, '0, total_r, '0); n_v = n_v + 2'd1;
              phase_nxt = PH_STOPPED;
            end
          end
        end
        default: phase_nxt = PH_STOPPED;
      endcase
    end

    // header complete: check magic and footprint, then open the first section
    if (do_hdr) begin
      if (magic_nxt != MAGIC_WORD) begin
        slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_BAD_MAGIC); n_v = n_v + 2'd1;
        phase_nxt = PH_STOPPED;
      end else if (foot_r > {10'd0, maxf_r}) begin
        slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_TOO_LARGE); n_v = n_v + 2'd1;
        phase_nxt = PH_STOPPED;
      end else if (content_r != 33'd0) begin
        phase_nxt = PH_CONTENT;
        cnt_nxt = '0;
        if (eof) begin
          slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_BODY); n_v = n_v + 2'd1;
          phase_nxt = PH_STOPPED;
        end
      end else begin
        do_after = 1'b1;
      end
    end
    if (do_after) begin
      if (bss_r != 32'd0) begin
        slot_v[n_v] = mk_res(K_CLEAR, base_r + content_r[ADDR_W-1:0], bss_r, '0);
        n_v = n_v + 2'd1;
      end
      do_sym = 1'b1;
    end
    if (do_sym) begin
      if (sym_r != 32'd0) begin
        phase_nxt = PH_SYMBOLS;
        cnt_nxt = '0;
        if (eof) begin
          slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_SYM); n_v = n_v + 2'd1;
          phase_nxt = PH_STOPPED;
        end
      end else begin
        do_fix = 1'b1;
      end
    end
    if (do_fix) begin
      if (abs_nxt != 16'd0) begin
        slot_v[n_v] = mk_res(K_DONE, '0, total_r, '0); n_v = n_v + 2'd1;
        phase_nxt = PH_STOPPED;
      end else begin
        phase_nxt = PH_FIXSTART;
        cnt_nxt = '0;
        fix_nxt = '0;
        if (eof) begin
          slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_SHORT_FIX); n_v = n_v + 2'd1;
          phase_nxt = PH_STOPPED;
        end
      end
    end
    // range check and relocate one longword
    if (do_apply) begin
      if ({2'b0, fix_nxt} + 34'd4 > {1'b0, content_r}) begin
        slot_v[n_v] = mk_res(K_ERROR, '0, '0, E_FIX_RANGE); n_v = n_v + 2'd1;
        phase_nxt = PH_STOPPED;
      end else begin
        slot_v[n_v] = mk_res(K_RELOC, base_r + fix_nxt[ADDR_W-1:0], {8'd0, base_r}, '0);
        n_v = n_v + 2'd1;
        total_nxt = total_r + 32'd1;
        phase_nxt = PH_FIXLIST;
        if (eof) begin
          slot_v[n_v] = mk_res(K_DONE, '0, total_nxt, '0); n_v = n_v + 2'd1;
          phase_nxt = PH_STOPPED;
        end
      end
    end
  end

  assign push      = acc && (n_v != 2'd0);
  assign bund.cnt  = n_v;
  assign bund.slot = slot_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= LOAD_BASE_RST; maxf_r <= MAX_FOOT_RST;
      phase_r <= PH_HEADER; cnt_r <= '0; magic_r <= '0; abs_r <= '0;
      text_r <= '0; data_r <= '0; bss_r <= '0; sym_r <= '0;
      fix_r <= '0; total_r <= '0; content_r <= '0; foot_r <= '0;
    end else begin
      if (cfg_wen && cfg_index == REG_LOAD_BASE) base_r <= cfg_wdata;
      if (cfg_wen && cfg_index == REG_MAX_FOOT)  maxf_r <= cfg_wdata;
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; magic_r <= magic_nxt; abs_r <= abs_nxt;
      text_r <= text_nxt; data_r <= data_nxt; bss_r <= bss_nxt; sym_r <= sym_nxt;
      fix_r <= fix_nxt; total_r <= total_nxt;
      // sizes settle early in the header; content_r is registered from them and foot_r from content_r
      content_r <= {1'b0, text_r} + {1'b0, data_r};
      foot_r    <= {1'b0, content_r} + {2'b0, bss_r};
    end
  end

endmodule

@@ rtl/core/pil_queue.sv @@
// Short bundle queue between the front parser and the back sequencer.
// Depends on pil_pkg.
module pil_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pil_pkg::bund_t  push_data,
  input  logic            pop,
  output pil_pkg::bund_t  pop_data,
  output logic            full,
  output logic            nonempty
);
  import pil_pkg::*;

  bund_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full     = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !nonempty))
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count out of range");
  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_data.cnt != 2'd0)
    else $error("empty bundle queued");
`endif

endmodule

@@ rtl/core/pil_back.sv @@
// Back sequencer: takes bundles from the queue and hands out their results
// one per cycle on the result channel while out_ready is high. Depends on pil_pkg.
module pil_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  pil_pkg::bund_t  q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output pil_pkg::res_t   out_res,
  output logic            out_last
);
  import pil_pkg::*;

  bund_t      cur_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic       fire;

  assign out_valid = valid_r;
  assign out_res   = cur_r.slot[idx_r];
  assign out_last  = (idx_r == cur_r.cnt - 2'd1);
  assign fire      = valid_r && out_ready;
  assign q_pop     = q_nonempty && (!valid_r || (fire && out_last));

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (fire) begin
      if (out_last) valid_r <= 1'b0;
      else          idx_r   <= idx_r + 2'd1;
    end
  end

endmodule

@@ rtl/core/prg_image_loader_relocator_unit.sv @@
// Top level of the executable image loader/relocator.
// Instantiates pil_front, pil_queue and pil_back; depends on pil_pkg.
//
// Usage:
//   in_*  : one file byte per item, in_tdata[7:0] = byte, in_tlast marks end of file.
//   out_* : memory commands; out_tuser = command kind, out_tlast marks the last
//           command caused by one input byte.
//   cfg_* : load base (index 0) and footprint limit (index 1), written while idle.
// The front parser takes one byte per cycle while the queue is not full and
// turns it into a bundle of up to three commands in the same cycle; a four-entry
// bundle queue feeds the back sequencer, which drives one command per cycle from
// its output register while out_tready is high. With the queue and the back
// sequencer empty, an accepted byte's bundle is written into the queue and then
// loaded into the output register, which raises out_tvalid. The input sustains
// one byte per cycle while bytes cause one command at most and out_tready is
// high; bytes with two or three commands slow it to the single result port.
// A stalled receiver fills the queue, after which in_tready drops until space
// frees up; nothing is lost. Synchronous reset clears the parser to the header
// phase, empties the queue and restores the register defaults.
module prg_image_loader_relocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wen,
  input  logic                      cfg_index,
  input  logic [pil_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] file_byte
  input  logic                      in_tlast,   // end_of_file
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [63:0]               out_tdata,  // [23:0] mem_address, [55:24] cmd_value,
                                                // [58:56] error_code, rest zero
  output logic [2:0]                out_tuser,  // [2:0] cmd_kind
  output logic                      out_tlast   // last_of_run
);
  import pil_pkg::*;

  logic  acc, push, pop, full, nonempty;
  bund_t push_b, pop_b;
  res_t  res;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  pil_front u_front (
    .clk, .rst_n, .cfg_wen, .cfg_index, .cfg_wdata,
    .acc, .byte_in(in_tdata), .eof(in_tlast),
    .push, .bund(push_b)
  );

  pil_queue u_queue (
    .clk, .rst_n, .push, .push_data(push_b),
    .pop, .pop_data(pop_b), .full, .nonempty
  );

  pil_back u_back (
    .clk, .rst_n, .q_nonempty(nonempty), .q_data(pop_b), .q_pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res), .out_last(out_tlast)
  );

  // pack the result fields, lowest first
  assign out_tdata = {5'd0, res.err, res.value, res.addr};
  assign out_tuser = res.kind;

endmodule

@@ bench/prg_image_loader_relocator_checker.sv @@
// Scoreboard for the image loader/relocator: snoops config writes and both streams,
// predicts the command items of every accepted file byte and compares them.
// Depends on pil_pkg for widths, command kinds, error codes and register indexes.
`timescale 1ns / 1ps

module prg_image_loader_relocator_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wen,
  input  logic                      cfg_index,
  input  logic [pil_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] file_byte
  input  logic                      in_tlast,   // end_of_file
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [63:0]               out_tdata,  // [23:0] mem_address, [55:24] cmd_value,
                                                // [58:56] error_code
  input  logic [2:0]                out_tuser,  // [2:0] cmd_kind
  input  logic                      out_tlast,  // last_of_run
  output int                        fail_count,
  output int                        pending
);
  import pil_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER, ST_BODY, ST_SYMS, ST_FIXSTART, ST_FIXLIST, ST_STOPPED
  } load_phase_t;

  typedef struct {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
    logic [2:0]        err;
    logic              last;
  } mem_cmd_t;

  mem_cmd_t    cmd_expect_q[$];
  mem_cmd_t    batch[$];
  load_phase_t phase;
  logic [31:0] cnt, text_len, data_len, bss_len, sym_len, fix_off, fix_total;
  logic [15:0] magic, no_reloc_word;
  logic [CFG_W-1:0] base, foot_limit;

  function automatic logic [63:0] body_len();
    return {32'd0, text_len} + {32'd0, data_len};
  endfunction

  function automatic logic [ADDR_W-1:0] target(logic [63:0] rel);
    logic [63:0] s;
    s = {40'd0, base} + rel;
    return s[ADDR_W-1:0];
  endfunction

  task automatic emit(logic [2:0] k, logic [ADDR_W-1:0] a, logic [31:0] v, logic [2:0] e);
    mem_cmd_t c;
    c.kind = k; c.addr = a; c.value = v; c.err = e; c.last = 1'b0;
    batch.push_back(c);
  endtask

  task automatic abort(logic [2:0] e);
    emit(K_ERROR, '0, '0, e);
    phase = ST_STOPPED;
  endtask

  task automatic complete();
    emit(K_DONE, '0, fix_total, '0);
    phase = ST_STOPPED;
  endtask

  task automatic open_fixups(logic eof);
    if (no_reloc_word != 0) begin
      complete();
      return;
    end
    phase = ST_FIXSTART; cnt = 0; fix_off = 0;
    if (eof) abort(E_SHORT_FIX);
  endtask

  task automatic open_symbols(logic eof);
    if (sym_len != 0) begin
      phase = ST_SYMS; cnt = 0;
      if (eof) abort(E_SHORT_SYM);
    end else begin
      open_fixups(eof);
    end
  endtask

  task automatic close_body(logic eof);
    if (bss_len != 0) emit(K_CLEAR, target(body_len()), bss_len, '0);
    open_symbols(eof);
  endtask

  task automatic relocate(logic eof);
    if ({32'd0, fix_off} + 64'd4 > body_len()) begin
      abort(E_FIX_RANGE);
      return;
    end
    emit(K_RELOC, target({32'd0, fix_off}), {8'd0, base}, '0);
    fix_total++;
    phase = ST_FIXLIST;
    if (eof) complete();
  endtask

  task automatic check_header(logic eof);
    if (magic != MAGIC_WORD) abort(E_BAD_MAGIC);
    else if (body_len() + {32'd0, bss_len} > {40'd0, foot_limit}) abort(E_TOO_LARGE);
    else if (body_len() != 0) begin
      phase = ST_BODY; cnt = 0;
      if (eof) abort(E_SHORT_BODY);
    end else close_body(eof);
  endtask

  // Advance the loader state by one file byte and queue the commands it causes.
  task automatic predict_commands(logic [7:0] b, logic eof);
    logic [63:0] s;
    batch.delete();
    case (phase)
      ST_HEADER: begin
        if (cnt < 2) magic = {magic[7:0], b};
        else if (cnt < 6) text_len = {text_len[23:0], b};
        else if (cnt < 10) data_len = {data_len[23:0], b};
        else if (cnt < 14) bss_len = {bss_len[23:0], b};
        else if (cnt < 18) sym_len = {sym_len[23:0], b};
        else if (cnt >= 26 && cnt < 28) no_reloc_word = {no_reloc_word[7:0], b};
        cnt++;
        if (cnt >= HEADER_BYTES) check_header(eof);
        else if (eof) abort(E_SHORT_HDR);
      end
      ST_BODY: begin
        emit(K_WRITE, target({32'd0, cnt}), {24'd0, b}, '0);
        cnt++;
        if ({32'd0, cnt} >= body_len()) close_body(eof);
        else if (eof) abort(E_SHORT_BODY);
      end
      ST_SYMS: begin
        cnt++;
        if (cnt >= sym_len) open_fixups(eof);
        else if (eof) abort(E_SHORT_SYM);
      end
      ST_FIXSTART: begin
        fix_off = {fix_off[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          if (fix_off == 0) complete();
          else relocate(eof);
        end else if (eof) abort(E_SHORT_FIX);
      end
      ST_FIXLIST: begin
        if (b == 8'h00) complete();
        else begin
          // 0x01 skips 254 bytes without relocating; the offset saturates
          s = {32'd0, fix_off} + ((b == 8'h01) ? 64'd254 : {56'd0, b});
          fix_off = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
          if (b == 8'h01) begin
            if (eof) complete();
          end else relocate(eof);
        end
      end
      default: phase = ST_STOPPED;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) cmd_expect_q.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    mem_cmd_t e;
    if (!rst_n) begin
      cmd_expect_q.delete();
      phase = ST_HEADER;
      cnt = 0; text_len = 0; data_len = 0; bss_len = 0; sym_len = 0;
      fix_off = 0; fix_total = 0; magic = 0; no_reloc_word = 0;
      base = LOAD_BASE_RST; foot_limit = MAX_FOOT_RST;
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (cmd_expect_q.size() == 0) begin
          $error("unexpected command item kind=%0d", out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = cmd_expect_q.pop_front();
          if (out_tuser !== e.kind ||
              out_tdata[23:0] !== e.addr || out_tdata[55:24] !== e.value ||
              out_tdata[58:56] !== e.err || out_tlast !== e.last)
            fail_count <= fail_count + 1;
          if (out_tuser !== e.kind)
            $error("cmd_kind: expected %0d, got %0d", e.kind, out_tuser);
          if (out_tdata[23:0] !== e.addr)
            $error("mem_address: expected %h, got %h", e.addr, out_tdata[23:0]);
          if (out_tdata[55:24] !== e.value)
            $error("cmd_value: expected %h, got %h", e.value, out_tdata[55:24]);
          if (out_tdata[58:56] !== e.err)
            $error("error_code: expected %0d, got %0d", e.err, out_tdata[58:56]);
          if (out_tlast !== e.last)
            $error("last_of_run: expected %0d, got %0d", e.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_commands(in_tdata, in_tlast);
      if (cfg_wen) begin
        if (cfg_index == REG_LOAD_BASE) base = cfg_wdata;
        else foot_limit = cfg_wdata;
      end
    end
    pending <= cmd_expect_q.size();
  end

endmodule

@@ bench/prg_image_loader_relocator_unit_tb.sv @@
// Top of the loader/relocator bench: clock, reset, config writes and a random
// executable image streamed byte by byte; checking lives in the checker module.
// Depends on pil_pkg, prg_image_loader_relocator_unit and the checker.
`timescale 1ns / 1ps

module prg_image_loader_relocator_unit_tb;
  import pil_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic clk, rst_n;
  logic cfg_wen, cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  int fail_count, pending;

  int cycles = 0;
  int sent = 0;
  int tx_idle_pct = 36;
  int rx_idle_pct = 84;
  bit held = 0;

  prg_image_loader_relocator_unit uut (.*);
  prg_image_loader_relocator_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once the stream is
  // well into the body so the result queue fills and in_tready drops.
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (!held && sent >= 40) begin
        held = 1;
        out_tready <= 0;
        repeat (300) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one file byte, idling at random first; return once it is accepted.
  task automatic send_byte(logic [7:0] b, logic eof);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Hold the input until every expected item is out, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 0;
  endtask

  task automatic push_be32(ref logic [7:0] q[$], input logic [31:0] v);
    for (int k = 3; k >= 0; k--) q.push_back(v[k*8 +: 8]);
  endtask

  initial begin
    logic [7:0] file_q[$];
    logic       eof_q[$];
    int text_len, data_len, bss_len, sym_len, body, off, ending, mid, nfix;

    in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_wen = 0; cfg_index = REG_LOAD_BASE; cfg_wdata = 0;
    rst_n = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;

    // Build the image: header, body, symbols, fixup list, then ignored tail.
    text_len = $urandom_range(60, 110);
    data_len = $urandom_range(0, 40);
    bss_len  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5000);
    sym_len  = $urandom_range(0, 8);
    body     = text_len + data_len;

    file_q.push_back(MAGIC_WORD[15:8]);
    file_q.push_back(MAGIC_WORD[7:0]);
    push_be32(file_q, text_len);
    push_be32(file_q, data_len);
    push_be32(file_q, bss_len);
    push_be32(file_q, sym_len);
    repeat (8) file_q.push_back(8'($urandom_range(0, 255)));
    file_q.push_back(8'h00);
    file_q.push_back(8'h00);
    repeat (body + sym_len) file_q.push_back(8'($urandom_range(0, 255)));
    off = $urandom_range(1, 6);
    push_be32(file_q, off);
    nfix = 0;
    while (nfix < 40 && off + 10 <= body) begin
      int step;
      step = $urandom_range(2, 6);
      file_q.push_back(8'(step));
      off += step;
      nfix++;
    end
    ending = $urandom_range(0, 3);
    case (ending)
      0: file_q.push_back(8'h00);  // end of list
      1: file_q.push_back(8'h01);  // skip 254, then run past the body
      2: file_q.push_back(8'hFF);  // oversized step, out of range
      default: ;                   // end of file inside the list
    endcase
    if (ending == 1) file_q.push_back(8'h02);
    foreach (file_q[k]) eof_q.push_back(ending == 3 && k == file_q.size() - 1);
    repeat (2) begin
      file_q.push_back(8'($urandom_range(0, 255)));
      eof_q.push_back(1'b0);
    end
    file_q.push_back(8'hA5);
    eof_q.push_back(1'b1);

    // Base near the top of memory so body addresses wrap; limit exactly at the footprint.
    write_reg(REG_LOAD_BASE, 24'hFFFFC0);
    write_reg(REG_MAX_FOOT, CFG_W'(body + bss_len));

    mid = HEADER_BYTES + body / 2;
    foreach (file_q[k]) begin
      if (k == file_q.size() / 3) begin
        tx_idle_pct = 84; rx_idle_pct = 36;
      end
      if (k == 2 * file_q.size() / 3) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      // Pause mid-body for every result, then move the base to zero.
      if (k == mid) begin
        drain();
        write_reg(REG_LOAD_BASE, 24'h000000);
      end
      send_byte(file_q[k], eof_q[k]);
    end
    drain();
    write_reg(REG_MAX_FOOT, 24'h000000);
    write_reg(REG_LOAD_BASE, 24'hFFFFFF);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
